@@ src/qoi_enc_pkg.sv @@
// ----------------------------------------------------------------------------
// qoi_enc_pkg
// Shared types, constants and the colour index hash of the QOI stream encoder.
// ----------------------------------------------------------------------------
package qoi_enc_pkg;

  localparam int PX_W      = 32;
  localparam int IDX_DEPTH = 64;
  localparam int IDX_AW    = $clog2(IDX_DEPTH);
  localparam int MAX_BYTES = 6;
  localparam int CNT_W     = $clog2(MAX_BYTES + 1);
  localparam int RUN_W     = 6;

  localparam logic [7:0] OP_RUN  = 8'hc0;
  localparam logic [7:0] OP_DIFF = 8'h40;
  localparam logic [7:0] OP_LUMA = 8'h80;
  localparam logic [7:0] OP_RGB  = 8'hfe;
  localparam logic [7:0] OP_RGBA = 8'hff;

  localparam logic [RUN_W-1:0] RUN_LAST = 6'd61;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  localparam pixel_t PX_RESET = '{alpha: 8'hff, blue: 8'h00, green: 8'h00, red: 8'h00};

  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [CNT_W-1:0]          cnt;
    logic                      image_end;
  } op_rec_t;

  function automatic logic [IDX_AW-1:0] px_hash(input pixel_t p);
    logic [IDX_AW-1:0] r3;
    logic [IDX_AW-1:0] g5;
    logic [IDX_AW-1:0] b7;
    logic [IDX_AW-1:0] a11;
    r3  = p.red[IDX_AW-1:0] * 6'd3;
    g5  = p.green[IDX_AW-1:0] * 6'd5;
    b7  = p.blue[IDX_AW-1:0] * 6'd7;
    a11 = p.alpha[IDX_AW-1:0] * 6'd11;
    return r3 + g5 + b7 + a11;
  endfunction

endpackage

@@ src/qoi_pixel_stream_encoder_top.sv @@
// ----------------------------------------------------------------------------
// qoi_pixel_stream_encoder_top
// QOI op stream encoder for a stream of RGBA pixels, without header or end
// marker.
//
// The slave stream carries one pixel per transaction; tlast marks the final
// pixel of the image. The master stream carries one op byte per transaction;
// tuser marks the final byte caused by a pixel and tlast the final byte of
// the image. A pixel that only extends a run causes no transaction.
// A pixel's first byte is offered after the pixel passes the index stage
// into the serializer. A pixel is taken every cycle while each pixel yields
// at most one byte and the receiver is ready; more bytes per pixel hold the
// single-byte output port longer, so throughput is set by that port. The
// colour index lives in a 64-entry RAM with a registered read; the write of
// one pixel is forwarded to the next so back-to-back pixels at one index see
// each other. Reset, and the end of each image, restore the previous pixel
// to opaque black, clear the run count and invalidate the colour index. When
// the receiver stalls, the pending bytes wait in the serializer and one more
// pixel waits in the index stage before s_axis_tready drops.
// ----------------------------------------------------------------------------
module qoi_pixel_stream_encoder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // red, green, blue, alpha
  input  logic        s_axis_tlast,   // last_pixel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_byte
  output logic        m_axis_tlast,   // image_end
  output logic        m_axis_tuser    // last_of_item
);

  import qoi_enc_pkg::*;

  op_rec_t rec;
  logic    rec_valid;
  logic    rec_ready;

  qoi_enc_core u_core (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_px    (pixel_t'(s_axis_tdata)),
    .in_last  (s_axis_tlast),
    .rec_valid(rec_valid),
    .rec_ready(rec_ready),
    .rec      (rec)
  );

  qoi_enc_ser u_ser (
    .clk             (clk),
    .rst             (rst),
    .rec_valid       (rec_valid),
    .rec_ready       (rec_ready),
    .rec             (rec),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .out_byte        (m_axis_tdata),
    .out_last_of_item(m_axis_tuser),
    .out_image_end   (m_axis_tlast)
  );

endmodule

@@ src/qoi_enc_ram.sv @@
// ----------------------------------------------------------------------------
// qoi_enc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module qoi_enc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ src/qoi_enc_core.sv @@
// ----------------------------------------------------------------------------
// qoi_enc_core
// Hash and index read stage, then op selection with previous pixel, run count
// and read-modify-write of the colour index.
// ----------------------------------------------------------------------------
module qoi_enc_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  qoi_enc_pkg::pixel_t in_px,
  input  logic                in_last,
  output logic                rec_valid,
  input  logic                rec_ready,
  output qoi_enc_pkg::op_rec_t rec
);

  import qoi_enc_pkg::*;

  logic              in_fire;
  logic              fire;
  logic              s1_valid;
  pixel_t            s1_px;
  logic              s1_last;
  logic [IDX_AW-1:0] s1_hash;

  pixel_t            prev;
  logic [RUN_W-1:0]  run;
  logic [RUN_W-1:0]  run_next;
  logic [IDX_DEPTH-1:0] valid;
  logic              fwd_v;
  logic [IDX_AW-1:0] fwd_addr;
  pixel_t            fwd_data;

  logic [PX_W-1:0]   ram_q;
  pixel_t            entry;
  logic              same;
  logic              hit;
  logic              we;

  logic [7:0]        dr;
  logic [7:0]        dg;
  logic [7:0]        db;
  logic [8:0]        rg;
  logic [8:0]        bg;
  logic [7:0]        dr2;
  logic [7:0]        dg2;
  logic [7:0]        db2;
  logic [7:0]        dg32;
  logic [8:0]        rg8;
  logic [8:0]        bg8;
  logic              diff_ok;
  logic              luma;

  logic [4:0][7:0]   ob;
  logic [CNT_W-1:0]  ocnt;
  logic              run_emit;
  logic [7:0]        run_byte;

  assign in_fire  = in_valid && in_ready;
  assign fire     = s1_valid && (rec_ready || rec.cnt == '0);
  assign in_ready = !s1_valid || fire;
  assign rec_valid = s1_valid;

  qoi_enc_ram #(
    .WIDTH(PX_W),
    .DEPTH(IDX_DEPTH)
  ) u_index (
    .clk    (clk),
    .wr_en  (we),
    .wr_addr(s1_hash),
    .wr_data(s1_px),
    .rd_en  (in_fire),
    .rd_addr(px_hash(in_px)),
    .rd_data(ram_q)
  );

  always_comb begin
    if (fwd_v && fwd_addr == s1_hash) begin
      entry = fwd_data;
    end else if (valid[s1_hash]) begin
      entry = pixel_t'(ram_q);
    end else begin
      entry = '0;
    end
  end

  assign same = (s1_px == prev);
  assign hit  = (entry == s1_px);
  assign we   = fire && !same && !hit;

  assign dr   = s1_px.red - prev.red;
  assign dg   = s1_px.green - prev.green;
  assign db   = s1_px.blue - prev.blue;
  assign rg   = {dr[7], dr} - {dg[7], dg};
  assign bg   = {db[7], db} - {dg[7], dg};
  assign dr2  = dr + 8'd2;
  assign dg2  = dg + 8'd2;
  assign db2  = db + 8'd2;
  assign dg32 = dg + 8'd32;
  assign rg8  = rg + 9'd8;
  assign bg8  = bg + 9'd8;
  assign diff_ok = (dr2 < 8'd4) && (dg2 < 8'd4) && (db2 < 8'd4);
  assign luma  = (dg32 < 8'd64) && (rg8 < 9'd16) && (bg8 < 9'd16);

  always_comb begin
    ob   = '0;
    ocnt = '0;
    if (same) begin
      run_emit = (run == RUN_LAST) || s1_last;
      run_byte = OP_RUN | {2'b00, run};
      run_next = run_emit ? '0 : run + 6'd1;
    end else begin
      run_emit = (run != '0);
      run_byte = OP_RUN | {2'b00, run - 6'd1};
      run_next = '0;
      if (hit) begin
        ob[0] = {2'b00, s1_hash};
        ocnt  = 3'd1;
      end else if (s1_px.alpha != prev.alpha) begin
        ob   = {s1_px.alpha, s1_px.blue, s1_px.green, s1_px.red, OP_RGBA};
        ocnt = 3'd5;
      end else if (diff_ok) begin
        ob[0] = OP_DIFF | {2'b00, dr2[1:0], dg2[1:0], db2[1:0]};
        ocnt  = 3'd1;
      end else if (luma) begin
        ob[0] = OP_LUMA | {2'b00, dg32[5:0]};
        ob[1] = {rg8[3:0], bg8[3:0]};
        ocnt  = 3'd2;
      end else begin
        ob[3:0] = {s1_px.blue, s1_px.green, s1_px.red, OP_RGB};
        ocnt    = 3'd4;
      end
    end
  end

  always_comb begin
    if (run_emit) begin
      rec.bytes = {ob, run_byte};
    end else begin
      rec.bytes = {8'h00, ob};
    end
    rec.cnt       = {{(CNT_W-1){1'b0}}, run_emit} + ocnt;
    rec.image_end = s1_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_px   <= in_px;
      s1_last <= in_last;
      s1_hash <= px_hash(in_px);
    end
    if (we) begin
      fwd_addr <= s1_hash;
      fwd_data <= s1_px;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev  <= PX_RESET;
      run   <= '0;
      valid <= '0;
      fwd_v <= 1'b0;
    end else if (fire) begin
      if (s1_last) begin
        prev  <= PX_RESET;
        run   <= '0;
        valid <= '0;
        fwd_v <= 1'b0;
      end else begin
        if (!same) begin
          prev <= s1_px;
        end
        run <= run_next;
        if (we) begin
          valid[s1_hash] <= 1'b1;
          fwd_v          <= 1'b1;
        end
      end
    end
  end

endmodule

@@ src/qoi_enc_ser.sv @@
// ----------------------------------------------------------------------------
// qoi_enc_ser
// Output serializer: holds the bytes of one pixel and sends one per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module qoi_enc_ser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rec_valid,
  output logic                 rec_ready,
  input  qoi_enc_pkg::op_rec_t rec,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic                 out_last_of_item,
  output logic                 out_image_end
);

  import qoi_enc_pkg::*;

  logic [MAX_BYTES-1:0][7:0] hold;
  logic [CNT_W-1:0]          cnt;
  logic                      img_end;
  logic                      load;

  assign out_valid        = (cnt != '0);
  assign rec_ready        = (cnt == '0) || (cnt == 3'd1 && out_ready);
  assign load             = rec_valid && rec_ready;
  assign out_byte         = hold[0];
  assign out_last_of_item = (cnt == 3'd1);
  assign out_image_end    = img_end && (cnt == 3'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= rec.cnt;
    end else if (out_valid && out_ready) begin
      cnt <= cnt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold    <= rec.bytes;
      img_end <= rec.image_end;
    end else if (out_valid && out_ready) begin
      hold <= {8'h00, hold[MAX_BYTES-1:1]};
    end
  end

endmodule

@@ src/qoi_enc_checker.sv @@
// ----------------------------------------------------------------------------
// qoi_enc_checker
// Port-level checks of the QOI stream encoder, bound to the top level.
// ----------------------------------------------------------------------------
module qoi_enc_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser
);

  import qoi_enc_pkg::*;

  logic first_byte;
  logic run_code;
  logic run_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_byte <= 1'b1;
    end else if (m_axis_tvalid && m_axis_tready) begin
      first_byte <= m_axis_tuser;
    end
  end

  assign run_code = (m_axis_tdata[7:6] == OP_RUN[7:6]) && (m_axis_tdata < OP_RGB);
  assign run_byte = first_byte && run_code;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Output transaction changed while stalled.");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("Output valid right after reset.");

  a_end_is_item_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("Image end on a byte that does not end its pixel.");

  a_flush_then_op: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && run_byte && !m_axis_tuser
    |=> m_axis_tvalid && !run_code)
    else $error("Run flush not followed by the op of the same pixel.");

endmodule

bind qoi_pixel_stream_encoder_top qoi_enc_checker u_chk (
  .clk          (clk),
  .rst          (rst),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast),
  .m_axis_tuser (m_axis_tuser)
);

@@ sim/tb_qoi_pixel_stream_encoder_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_qoi_pixel_stream_encoder_top
// Self-checking testbench for the QOI pixel stream encoder.
//
// Pixels go in on the slave stream and op bytes come out on the master
// stream. A scoreboard object keeps its own copy of the previous pixel, the
// colour index and the run count. For every accepted pixel it works out the
// op bytes and flags the encoder should produce, and each byte that leaves
// the encoder is compared with the oldest one waiting.
//
// A short directed part covers runs, index hits, diff, luma, RGB and RGBA
// ops and the return to reset state at the end of an image. Random images
// follow, built mostly from runs and small steps that the compact ops can
// code, mixed with fully random pixels. Both sides idle at random, and once
// the receiver holds off long enough for the encoder to stall its input.
// ----------------------------------------------------------------------------
module tb_qoi_pixel_stream_encoder_top;
  import qoi_enc_pkg::*;

  localparam int RUN_LIMIT    = 62;
  localparam int IDLE_PCT     = 6;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_ITEMS = 160;

  typedef struct packed {
    logic [7:0] data;
    logic       item_end;
    logic       img_end;
  } op_byte_t;

  class qoi_scoreboard;
    pixel_t      prev_px;
    pixel_t      color_tab [IDX_DEPTH];
    int unsigned run_len;
    op_byte_t    expected_bytes [$];
    op_byte_t    pixel_bytes [$];
    int unsigned mismatches;

    function new();
      clear_state();
      mismatches = 0;
    endfunction

    function void clear_state();
      prev_px = PX_RESET;
      foreach (color_tab[i]) color_tab[i] = '0;
      run_len = 0;
    endfunction

    function int unsigned slot_of(pixel_t p);
      return (int'(p.red) * 3 + int'(p.green) * 5 + int'(p.blue) * 7 +
              int'(p.alpha) * 11) % IDX_DEPTH;
    endfunction

    function int step_of(logic [7:0] now, logic [7:0] was);
      logic [7:0] d;
      d = now - was;
      return int'($signed(d));
    endfunction

    function void emit(logic [7:0] b);
      op_byte_t r;
      r.data     = b;
      r.item_end = 1'b0;
      r.img_end  = 1'b0;
      pixel_bytes.push_back(r);
    endfunction

    function void note_pixel(pixel_t px, logic last);
      int          dr;
      int          dg;
      int          db;
      int          rg;
      int          bg;
      int unsigned h;
      op_byte_t    r;
      pixel_bytes.delete();
      if (px == prev_px) begin
        run_len++;
        if (run_len == RUN_LIMIT || last) begin
          emit(OP_RUN | 8'(run_len - 1));
          run_len = 0;
        end
      end else begin
        if (run_len > 0) begin
          emit(OP_RUN | 8'(run_len - 1));
          run_len = 0;
        end
        h = slot_of(px);
        if (color_tab[h] == px) begin
          emit(8'(h));
        end else begin
          color_tab[h] = px;
          if (px.alpha != prev_px.alpha) begin
            emit(OP_RGBA);
            emit(px.red);
            emit(px.green);
            emit(px.blue);
            emit(px.alpha);
          end else begin
            dr = step_of(px.red, prev_px.red);
            dg = step_of(px.green, prev_px.green);
            db = step_of(px.blue, prev_px.blue);
            rg = dr - dg;
            bg = db - dg;
            if (dr >= -2 && dr <= 1 && dg >= -2 && dg <= 1 && db >= -2 && db <= 1) begin
              emit(OP_DIFF | 8'((dr + 2) * 16 + (dg + 2) * 4 + (db + 2)));
            end else if (dg >= -32 && dg <= 31 && rg >= -8 && rg <= 7 &&
                         bg >= -8 && bg <= 7) begin
              emit(OP_LUMA | 8'(dg + 32));
              emit(8'((rg + 8) * 16 + (bg + 8)));
            end else begin
              emit(OP_RGB);
              emit(px.red);
              emit(px.green);
              emit(px.blue);
            end
          end
        end
        prev_px = px;
      end
      if (pixel_bytes.size() > 0) begin
        r          = pixel_bytes[pixel_bytes.size() - 1];
        r.item_end = 1'b1;
        r.img_end  = last;
        pixel_bytes[pixel_bytes.size() - 1] = r;
      end
      foreach (pixel_bytes[i]) expected_bytes.push_back(pixel_bytes[i]);
      if (last) clear_state();
    endfunction

    function void check_byte(logic [7:0] data, logic item_end, logic img_end);
      op_byte_t want;
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected byte %02h (last_of_item %0b image_end %0b), none pending",
                   data, item_end, img_end);
        return;
      end
      want = expected_bytes.pop_front();
      if (want.data !== data || want.item_end !== item_end || want.img_end !== img_end) begin
        mismatches++;
        if (mismatches <= 10)
          $display("byte mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b (data/user/last)",
                   want.data, want.item_end, want.img_end, data, item_end, img_end);
      end
    endfunction

    function int unsigned pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  qoi_scoreboard sb = new();

  bit          calm;
  bit          hold_req;
  bit          hold_done;
  pixel_t      gen_prev;
  int unsigned random_sent;

  qoi_pixel_stream_encoder_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_pixel(pixel_t'(s_axis_tdata), s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) sb.check_byte(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  function automatic pixel_t rgba(int r, int g, int b, int a);
    pixel_t p;
    p.red   = 8'(r);
    p.green = 8'(g);
    p.blue  = 8'(b);
    p.alpha = 8'(a);
    return p;
  endfunction

  task automatic send_pixel(input pixel_t px, input bit last);
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    gen_prev = last ? PX_RESET : px;
  endtask

  task automatic send_image(input int unsigned len);
    pixel_t      px;
    pixel_t      seen [$];
    int unsigned pick;
    int unsigned reps;
    int unsigned n;
    int          dg;
    n = 0;
    while (n < len) begin
      reps = 1;
      pick = $urandom_range(99);
      px   = gen_prev;
      if (pick < 25) begin
        reps = ($urandom_range(9) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 5);
      end else if (pick < 45) begin
        px.red   = 8'(int'(gen_prev.red) + int'($urandom_range(3)) - 2);
        px.green = 8'(int'(gen_prev.green) + int'($urandom_range(3)) - 2);
        px.blue  = 8'(int'(gen_prev.blue) + int'($urandom_range(3)) - 2);
      end else if (pick < 60) begin
        dg       = int'($urandom_range(63)) - 32;
        px.green = 8'(int'(gen_prev.green) + dg);
        px.red   = 8'(int'(gen_prev.red) + dg + int'($urandom_range(15)) - 8);
        px.blue  = 8'(int'(gen_prev.blue) + dg + int'($urandom_range(15)) - 8);
      end else if (pick < 72 && seen.size() > 0) begin
        px = seen[$urandom_range(seen.size() - 1)];
      end else if (pick < 82) begin
        px       = pixel_t'($urandom());
        px.alpha = gen_prev.alpha;
      end else begin
        px = pixel_t'($urandom());
      end
      if (reps > len - n) reps = len - n;
      repeat (reps) begin
        send_pixel(px, n == len - 1);
        n++;
        random_sent++;
      end
      seen.push_back(px);
      if (seen.size() > 12) void'(seen.pop_front());
    end
  endtask

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    pixel_t px;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    calm          = 1'b0;
    hold_req      = 1'b0;
    hold_done     = 1'b0;
    gen_prev      = PX_RESET;
    random_sent   = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // A run of the reset pixel, then transparent black, which hits the cleared index.
    send_pixel(rgba(0, 0, 0, 255), 1'b0);
    send_pixel(rgba(0, 0, 0, 255), 1'b0);
    send_pixel(rgba(0, 0, 0, 0), 1'b0);
    send_pixel(rgba(0, 0, 0, 255), 1'b0);
    send_pixel(rgba(1, 1, 1, 255), 1'b0);
    send_pixel(rgba(255, 255, 255, 255), 1'b0);
    send_pixel(rgba(5, 3, 1, 255), 1'b0);
    send_pixel(rgba(221, 227, 232, 255), 1'b0);
    send_pixel(rgba(3, 2, 255, 255), 1'b0);
    send_pixel(rgba(128, 0, 77, 255), 1'b0);
    send_pixel(rgba(1, 1, 1, 255), 1'b0);
    send_pixel(rgba(1, 1, 1, 255), 1'b0);
    send_pixel(rgba(1, 1, 1, 255), 1'b1);
    // A one-pixel image made of the reset pixel is a run flushed on the last pixel.
    send_pixel(rgba(0, 0, 0, 255), 1'b1);
    send_pixel(rgba(255, 255, 255, 0), 1'b0);
    send_pixel(rgba(0, 255, 0, 0), 1'b0);
    send_pixel(rgba(255, 0, 255, 255), 1'b1);
    send_pixel(rgba(0, 0, 0, 0), 1'b0);
    send_pixel(rgba(0, 0, 0, 0), 1'b0);
    send_pixel(rgba(10, 20, 30, 40), 1'b1);

    // One run long enough to reach the run limit and then flush on the last pixel.
    px = pixel_t'($urandom());
    for (int i = 0; i < 64; i++) begin
      send_pixel(px, i == 63);
      random_sent++;
    end

    while (random_sent < RANDOM_ITEMS) begin
      calm = (random_sent >= 60 && random_sent < 110);
      if (!hold_done && random_sent >= 120) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      send_image($urandom_range(1, 30));
    end
    calm = 1'b0;

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("qoi_pixel_stream_encoder_top test passed");
    end else begin
      $display("qoi_pixel_stream_encoder_top test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("qoi_pixel_stream_encoder_top test failed");
    $finish;
  end

endmodule

@@ sim.f @@
src/qoi_enc_pkg.sv
src/qoi_enc_ram.sv
src/qoi_enc_core.sv
src/qoi_enc_ser.sv
src/qoi_pixel_stream_encoder_top.sv
src/qoi_enc_checker.sv
sim/tb_qoi_pixel_stream_encoder_top.sv
